/* src/lrr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lrr_pkg;

  localparam int SCREEN_WIDTH  = 84;
  localparam int SCREEN_HEIGHT = 48;
  localparam int PAGE_ROWS     = 8;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);

  // coordinates and stepper arithmetic
  localparam int COORD_W = 8;
  localparam int DELTA_W = 10;
  localparam int ERR_W   = 12;

  typedef enum logic [1:0] {
    OP_LINE = 2'd0,
    OP_RECT = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_READ
  } state_e;

  typedef enum logic [2:0] {
    SEG_LINE,
    SEG_TOP,
    SEG_LEFT,
    SEG_BOTTOM,
    SEG_RIGHT,
    SEG_FILL
  } seg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
  } seg_t;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      done;
  } pix_t;

  typedef struct packed {
    logic              valid;
    logic              plot;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
  } mem_req_t;

  // byte address of an on-screen pixel: column plus page times width
  function automatic logic [ADDR_W-1:0] pixel_addr(input logic [6:0] col,
                                                   input logic [2:0] page);
    int a;
    a = int'(col) + int'(page) * SCREEN_WIDTH;
    return ADDR_W'(a);
  endfunction

endpackage

`default_nettype wire

/* src/lrr_cmd_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lrr_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic signed [7:0] start_x;
  logic signed [7:0] start_y;
  logic signed [7:0] end_x;
  logic signed [7:0] end_y;
  logic              fill;
  logic [8:0]        read_index;

  modport source (
    output valid, op, start_x, start_y, end_x, end_y, fill, read_index,
    input  ready
  );

  modport sink (
    input  valid, op, start_x, start_y, end_x, end_y, fill, read_index,
    output ready
  );
endinterface

`default_nettype wire

/* src/lrr_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface lrr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (
    output valid, read_data,
    input  ready
  );

  modport sink (
    input  valid, read_data,
    output ready
  );
endinterface

`default_nettype wire

/* src/lrr_line_stepper.sv */
`timescale 1ns / 1ps
`default_nettype none

module lrr_line_stepper (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire lrr_pkg::seg_t seg_i,
  output lrr_pkg::pix_t      pix_o
);
  import lrr_pkg::*;

  logic                      active_q, active_d;
  logic signed [COORD_W-1:0] x_q, x_d, y_q, y_d, x1_q, x1_d, y1_q, y1_d;
  logic signed [DELTA_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic                      negx_q, negx_d, negy_q, negy_d;
  logic signed [ERR_W-1:0]   err_q, err_d;

  logic                      at_end;
  logic signed [ERR_W:0]     e2;
  logic                      step_x, step_y;
  logic signed [DELTA_W-1:0] xd, yd, adx, ady;

  always_comb begin
    at_end = (x_q == x1_q) && (y_q == y1_q);
    e2     = {err_q, 1'b0};
    step_x = e2 >= (ERR_W+1)'(dy_q);
    step_y = e2 <= (ERR_W+1)'(dx_q);

    // deltas for a new segment
    xd  = DELTA_W'(seg_i.x1) - DELTA_W'(seg_i.x0);
    yd  = DELTA_W'(seg_i.y1) - DELTA_W'(seg_i.y0);
    adx = xd[DELTA_W-1] ? -xd : xd;
    ady = yd[DELTA_W-1] ? -yd : yd;

    active_d = active_q;
    x_d      = x_q;
    y_d      = y_q;
    x1_d     = x1_q;
    y1_d     = y1_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    negx_d   = negx_q;
    negy_d   = negy_q;
    err_d    = err_q;

    if (load_i) begin
      active_d = 1'b1;
      x_d      = seg_i.x0;
      y_d      = seg_i.y0;
      x1_d     = seg_i.x1;
      y1_d     = seg_i.y1;
      dx_d     = adx;
      dy_d     = -ady;
      negx_d   = !(seg_i.x0 < seg_i.x1);
      negy_d   = !(seg_i.y0 < seg_i.y1);
      err_d    = ERR_W'(adx) - ERR_W'(ady);
    end else if (active_q && at_end) begin
      active_d = 1'b0;
    end else if (active_q) begin
      err_d = err_q + (step_x ? ERR_W'(dy_q) : '0) + (step_y ? ERR_W'(dx_q) : '0);
      if (step_x) begin
        x_d = negx_q ? x_q - 8'sd1 : x_q + 8'sd1;
      end
      if (step_y) begin
        y_d = negy_q ? y_q - 8'sd1 : y_q + 8'sd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    negx_q <= negx_d;
    negy_q <= negy_d;
    err_q  <= err_d;
  end

  assign pix_o.valid = active_q;
  assign pix_o.x     = x_q;
  assign pix_o.y     = y_q;
  assign pix_o.done  = active_q && at_end;

  // a new segment only once the current one has reached its end
  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!active_q || at_end))
    else $error("segment loaded while stepper mid-line");

endmodule

`default_nettype wire

/* src/lrr_fb_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module lrr_fb_mem (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire lrr_pkg::mem_req_t         req_i,
  input  wire logic                      clr_we_i,
  input  wire logic [lrr_pkg::ADDR_W-1:0] clr_addr_i,
  output logic                           rsp_valid_o,
  output logic [7:0]                     rsp_data_o
);
  import lrr_pkg::*;

  logic [7:0]        mem_q [STORE_BYTES];
  logic [7:0]        rdata_q;

  logic              s1_valid_q, s1_plot_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [7:0]        s1_mask_q;

  // last write, for a read issued in the same cycle as that write
  logic              lw_valid_q;
  logic [ADDR_W-1:0] lw_addr_q;
  logic [7:0]        lw_data_q;

  logic [7:0]        cur;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  always_comb begin
    cur     = (lw_valid_q && (lw_addr_q == s1_addr_q)) ? lw_data_q : rdata_q;
    wr_en   = clr_we_i || (s1_valid_q && s1_plot_q);
    wr_addr = clr_we_i ? clr_addr_i : s1_addr_q;
    wr_data = clr_we_i ? 8'h00 : (cur | s1_mask_q);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (req_i.valid) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      lw_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i.valid;
      if (wr_en) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_plot_q <= req_i.plot;
    s1_addr_q <= req_i.addr;
    s1_mask_q <= req_i.mask;
    if (wr_en) begin
      lw_addr_q <= wr_addr;
      lw_data_q <= wr_data;
    end
  end

  assign rsp_valid_o = s1_valid_q && !s1_plot_q;
  assign rsp_data_o  = cur;

  a_clear_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_we_i |-> !s1_valid_q && !req_i.valid)
    else $error("clearing pass overlaps a pixel or read access");

endmodule

`default_nettype wire

/* src/line_rect_rasterizer.sv */
`timescale 1ns / 1ps
`default_nettype none

// draw commands: result word (zero) is loaded with acceptance; a line visits
//   max(|dx|,|dy|)+1 pixels, each on-screen one plotted by read-modify-write of its byte
// rect: its four outlines plus one vertical line per fill column, back to back;
//   next command taken once back in idle with the result word free
// read: result word loaded in the cycle after acceptance (zero with acceptance if out of range)
// reset: clearing pass zeroes all STORE_BYTES bytes (504 at 84x48), commands refused meanwhile
module line_rect_rasterizer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lrr_cmd_if.sink    cmd_i,
  lrr_rsp_if.source  rsp_o
);
  import lrr_pkg::*;

  state_e              state_q, state_d;
  seg_e                seg_q, seg_d;
  logic signed [7:0]   sx_q, sy_q, ex_q, ey_q;
  logic                fill_q;
  logic signed [7:0]   col_q, col_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_data_q, out_data_d;

  logic                accept;
  logic                read_in_range;
  logic                push;
  logic [7:0]          push_data;
  logic                load;
  seg_t                load_seg;
  seg_t                next_seg;
  seg_e                next_kind;
  logic                more;
  logic signed [7:0]   col_nx;
  pix_t                pix;
  logic                on_screen;
  mem_req_t            mem_req;
  logic                clr_we;
  logic                mem_rsp_valid;
  logic [7:0]          mem_rsp_data;

  // the outline and fill segments of a rectangle, one after another
  always_comb begin
    next_kind = seg_q;
    next_seg  = '{x0: sx_q, y0: sy_q, x1: sx_q, y1: ey_q};
    more      = 1'b0;
    col_nx    = col_q + 8'sd1;
    col_d     = col_q;
    unique case (seg_q)
      SEG_TOP: begin
        next_kind = SEG_LEFT;
        more      = 1'b1;
      end
      SEG_LEFT: begin
        next_kind = SEG_BOTTOM;
        next_seg  = '{x0: sx_q, y0: ey_q, x1: ex_q, y1: ey_q};
        more      = 1'b1;
      end
      SEG_BOTTOM: begin
        next_kind = SEG_RIGHT;
        next_seg  = '{x0: ex_q, y0: sy_q, x1: ex_q, y1: ey_q};
        more      = 1'b1;
      end
      SEG_RIGHT: begin
        // fill columns run from start_x up to end_x minus one
        if (fill_q && (ex_q > sx_q)) begin
          next_kind = SEG_FILL;
          col_d     = sx_q;
          more      = 1'b1;
        end
      end
      SEG_FILL: begin
        if (col_nx != ex_q) begin
          next_seg = '{x0: col_nx, y0: sy_q, x1: col_nx, y1: ey_q};
          col_d    = col_nx;
          more     = 1'b1;
        end
      end
      SEG_LINE: begin
        more = 1'b0;
      end
      default: begin
        more = 1'b0;
      end
    endcase
  end

  assign cmd_i.ready   = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept        = cmd_i.valid && cmd_i.ready;
  assign read_in_range = int'(cmd_i.read_index) < STORE_BYTES;

  // pixels outside the screen are dropped, the rest of the line goes on
  assign on_screen = pix.valid && (int'(pix.x) >= 0) && (int'(pix.x) < SCREEN_WIDTH)
                     && (int'(pix.y) >= 0) && (int'(pix.y) < SCREEN_HEIGHT);

  always_comb begin
    state_d     = state_q;
    seg_d       = seg_q;
    clr_d       = clr_q;
    clr_we      = 1'b0;
    load        = 1'b0;
    load_seg    = next_seg;
    push        = 1'b0;
    push_data   = 8'h00;
    mem_req     = '0;

    if (on_screen) begin
      mem_req.valid = 1'b1;
      mem_req.plot  = 1'b1;
      mem_req.addr  = pixel_addr(pix.x[6:0], pix.y[5:3]);
      mem_req.mask  = 8'h01 << pix.y[2:0];
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (int'(clr_q) == STORE_BYTES - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(cmd_i.op))
            OP_LINE: begin
              push     = 1'b1;
              load     = 1'b1;
              load_seg = '{x0: cmd_i.start_x, y0: cmd_i.start_y,
                           x1: cmd_i.end_x, y1: cmd_i.end_y};
              seg_d    = SEG_LINE;
              state_d  = ST_DRAW;
            end
            OP_RECT: begin
              push     = 1'b1;
              load     = 1'b1;
              load_seg = '{x0: cmd_i.start_x, y0: cmd_i.start_y,
                           x1: cmd_i.end_x, y1: cmd_i.start_y};
              seg_d    = SEG_TOP;
              state_d  = ST_DRAW;
            end
            OP_READ: begin
              if (read_in_range) begin
                mem_req.valid = 1'b1;
                mem_req.plot  = 1'b0;
                mem_req.addr  = ADDR_W'(cmd_i.read_index);
                state_d       = ST_READ;
              end else begin
                push = 1'b1;
              end
            end
            OP_NONE: begin
              push = 1'b1;
            end
          endcase
        end
      end
      ST_DRAW: begin
        if (pix.done) begin
          if (more) begin
            load  = 1'b1;
            seg_d = next_kind;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        push      = mem_rsp_valid;
        push_data = mem_rsp_data;
        state_d   = ST_IDLE;
      end
    endcase
  end

  // output word register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (push) begin
      out_valid_d = 1'b1;
      out_data_d  = push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      seg_q       <= SEG_LINE;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seg_q       <= seg_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // command fields, held for the segment sequence; also the result data and fill column
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (accept) begin
      sx_q   <= cmd_i.start_x;
      sy_q   <= cmd_i.start_y;
      ex_q   <= cmd_i.end_x;
      ey_q   <= cmd_i.end_y;
      fill_q <= cmd_i.fill;
    end
    if (state_q == ST_DRAW && pix.done) begin
      col_q <= col_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;

  lrr_line_stepper u_stepper (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .seg_i  (load_seg),
    .pix_o  (pix)
  );

  lrr_fb_mem u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .clr_we_i    (clr_we),
    .clr_addr_i  (clr_q),
    .rsp_valid_o (mem_rsp_valid),
    .rsp_data_o  (mem_rsp_data)
  );

  a_push_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_valid_q || rsp_o.ready))
    else $error("result word overwrites one not yet taken");

  a_pixels_in_draw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix.valid |-> (state_q == ST_DRAW))
    else $error("stepper active outside a draw");

  a_read_returns : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> mem_rsp_valid)
    else $error("read state without memory data");

endmodule

`default_nettype wire
